/* rtl/running_median_two_heaps_unit_macros.svh */
// Assertion macros used by the checker file.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_UNIT_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RM_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define RM_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

/* rtl/rmth_pkg.sv */
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared constants and types for the running median block.
// ----------------------------------------------------------------------------
package rmth_pkg;
    localparam int HEAP_DEPTH = 4096;
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = AW + 1;
    localparam int DW = 32;

    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] cnt_t;
    typedef logic signed [DW-1:0] data_t;

    // Heap operation requested from the sift engine.
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1
    } op_t;

    typedef enum logic [3:0] {
        SF_IDLE,
        SF_PUSH_RD,
        SF_PUSH_WT,
        SF_PUSH_CMP,
        SF_POP_LAST,
        SF_POP_LWT,
        SF_POP_RDC,
        SF_POP_WT1,
        SF_POP_WT2,
        SF_POP_CMP,
        SF_DONE
    } sift_state_t;

    typedef enum logic [3:0] {
        CT_IDLE,
        CT_INS,
        CT_INS_W,
        CT_TOPS,
        CT_TOPS_W,
        CT_TOPS_CHK,
        CT_POPL,
        CT_POPL_W,
        CT_POPU,
        CT_POPU_W,
        CT_PUSHL,
        CT_PUSHL_W,
        CT_PUSHU,
        CT_PUSHU_W,
        CT_RES_RD,
        CT_OUT
    } ctrl_state_t;

    // Command from the controller to one heap engine.
    typedef struct packed {
        logic  start;
        op_t   op;
        data_t value;
        logic  top_rd;
    } heap_cmd_t;

    // Status back from one heap engine.
    typedef struct packed {
        logic  done;
        cnt_t  count;
        data_t top;
    } heap_sts_t;

    // True if a ranks above b in the given heap kind.
    function automatic logic ranks_above(input data_t a, input data_t b, input logic is_max);
        logic r;
        begin
            r = is_max ? (a > b) : (a < b);
            return r;
        end
    endfunction
endpackage

/* rtl/rmth_heap.sv */
// ----------------------------------------------------------------------------
// rmth_heap
// One binary heap in a single-port memory with a sequential sift engine.
// ----------------------------------------------------------------------------
module rmth_heap (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               is_max,
    input  logic               clear,
    input  rmth_pkg::heap_cmd_t cmd,
    output rmth_pkg::heap_sts_t sts
);
    // Heap storage, one read or write per cycle. Read data holds until the
    // next read is issued.
    rmth_pkg::data_t mem [rmth_pkg::HEAP_DEPTH];
    rmth_pkg::data_t rdata_reg;
    logic            we;
    logic            re;
    logic            done;
    rmth_pkg::addr_t waddr;
    rmth_pkg::addr_t raddr;
    rmth_pkg::data_t wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    rmth_pkg::sift_state_t state_reg, state_next;
    rmth_pkg::cnt_t  count_reg, count_next;
    rmth_pkg::cnt_t  idx_reg, idx_next;     // hole position
    rmth_pkg::cnt_t  chi_reg, chi_next;     // left child / parent position
    rmth_pkg::cnt_t  n_reg, n_next;         // heap size during pop
    rmth_pkg::data_t val_reg, val_next;     // value being placed
    rmth_pkg::data_t cl_reg, cl_next;       // left child value

    // State and index registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmth_pkg::SF_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        chi_reg <= chi_next;
        n_reg   <= n_next;
        val_reg <= val_next;
        cl_reg  <= cl_next;
    end

    // Sift sequencer: push climbs toward the root, pop sinks from the root.
    always_comb
    begin
        rmth_pkg::cnt_t par;
        rmth_pkg::cnt_t rc;
        logic           take_r;
        rmth_pkg::data_t best;
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        chi_next   = chi_reg;
        n_next     = n_reg;
        val_next   = val_reg;
        cl_next    = cl_reg;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = idx_reg[rmth_pkg::AW-1:0];
        wdata      = val_reg;
        raddr      = '0;
        done       = 1'b0;
        par        = (idx_reg - 1'b1) >> 1;
        rc         = chi_reg + 1'b1;
        take_r     = (rc < n_reg) &&
                     rmth_pkg::ranks_above(rdata_reg, cl_reg, is_max);
        best       = take_r ? rdata_reg : cl_reg;
        case (state_reg)
            rmth_pkg::SF_IDLE:
            begin
                if (clear)
                begin
                    count_next = '0;
                end
                else if (cmd.start && cmd.op == rmth_pkg::OP_PUSH)
                begin
                    idx_next   = count_reg;
                    val_next   = cmd.value;
                    count_next = count_reg + 1'b1;
                    state_next = rmth_pkg::SF_PUSH_RD;
                end
                else if (cmd.start)
                begin
                    n_next     = count_reg - 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = rmth_pkg::SF_POP_LAST;
                end
            end
            rmth_pkg::SF_PUSH_RD:
            begin
                if (idx_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = rmth_pkg::SF_DONE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = par[rmth_pkg::AW-1:0];
                    chi_next   = par;
                    state_next = rmth_pkg::SF_PUSH_WT;
                end
            end
            rmth_pkg::SF_PUSH_WT:
            begin
                state_next = rmth_pkg::SF_PUSH_CMP;
            end
            rmth_pkg::SF_PUSH_CMP:
            begin
                if (rmth_pkg::ranks_above(val_reg, rdata_reg, is_max))
                begin
                    we         = 1'b1;
                    wdata      = rdata_reg;
                    idx_next   = chi_reg;
                    state_next = rmth_pkg::SF_PUSH_RD;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = rmth_pkg::SF_DONE;
                end
            end
            rmth_pkg::SF_POP_LAST:
            begin
                re         = 1'b1;
                raddr      = n_reg[rmth_pkg::AW-1:0];
                idx_next   = '0;
                chi_next   = rmth_pkg::cnt_t'(1);
                state_next = (n_reg == '0) ? rmth_pkg::SF_DONE : rmth_pkg::SF_POP_LWT;
            end
            rmth_pkg::SF_POP_LWT:
            begin
                val_next   = rdata_reg;
                state_next = rmth_pkg::SF_POP_RDC;
            end
            rmth_pkg::SF_POP_RDC:
            begin
                if (chi_reg < n_reg)
                begin
                    re         = 1'b1;
                    raddr      = chi_reg[rmth_pkg::AW-1:0];
                    state_next = rmth_pkg::SF_POP_WT1;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = rmth_pkg::SF_DONE;
                end
            end
            rmth_pkg::SF_POP_WT1:
            begin
                // Left child has landed; fetch the right child next.
                cl_next    = rdata_reg;
                re         = 1'b1;
                raddr      = rc[rmth_pkg::AW-1:0];
                state_next = rmth_pkg::SF_POP_WT2;
            end
            rmth_pkg::SF_POP_WT2:
            begin
                state_next = rmth_pkg::SF_POP_CMP;
            end
            rmth_pkg::SF_POP_CMP:
            begin
                if (rmth_pkg::ranks_above(val_reg, best, is_max))
                begin
                    we         = 1'b1;
                    state_next = rmth_pkg::SF_DONE;
                end
                else
                begin
                    we         = 1'b1;
                    wdata      = best;
                    idx_next   = take_r ? rc : chi_reg;
                    chi_next   = ((take_r ? rc : chi_reg) << 1) + 1'b1;
                    state_next = rmth_pkg::SF_POP_RDC;
                end
            end
            rmth_pkg::SF_DONE:
            begin
                done       = 1'b1;
                state_next = rmth_pkg::SF_IDLE;
            end
            default:
            begin
                state_next = rmth_pkg::SF_IDLE;
            end
        endcase
        // Top read for the controller when the engine is idle.
        if (state_reg == rmth_pkg::SF_IDLE && cmd.top_rd)
        begin
            re    = 1'b1;
            raddr = '0;
        end
    end

    assign sts.done  = done;
    assign sts.count = count_reg;
    assign sts.top   = rdata_reg;
endmodule

/* rtl/rmth_ctrl.sv */
// ----------------------------------------------------------------------------
// rmth_ctrl
// Item sequencer: insert, balance check, swap of tops, and result.
// ----------------------------------------------------------------------------
module rmth_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  rmth_pkg::data_t     sample,
    input  logic                restart,
    output logic                result_valid,
    input  logic                result_ready,
    output rmth_pkg::data_t     median,
    output logic [13:0]         held_count,
    output logic                dropped,
    output logic                clear,
    output rmth_pkg::heap_cmd_t lo_cmd,
    output rmth_pkg::heap_cmd_t up_cmd,
    input  rmth_pkg::heap_sts_t lo_sts,
    input  rmth_pkg::heap_sts_t up_sts
);
    rmth_pkg::ctrl_state_t state_reg, state_next;
    rmth_pkg::data_t smp_reg, smp_next;
    rmth_pkg::data_t a_reg, a_next;
    rmth_pkg::data_t b_reg, b_next;
    rmth_pkg::data_t med_reg, med_next;
    logic            drop_reg, drop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmth_pkg::CT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg   <= smp_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        med_reg   <= med_next;
        drop_reg  <= drop_next;
    end

    // Sequencer over the two heap engines.
    always_comb
    begin
        state_next   = state_reg;
        smp_next     = smp_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        med_next     = med_reg;
        drop_next    = drop_reg;
        sample_ready = 1'b0;
        result_valid = 1'b0;
        clear        = 1'b0;
        lo_cmd       = '0;
        up_cmd       = '0;
        case (state_reg)
            rmth_pkg::CT_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    smp_next   = sample;
                    clear      = restart;
                    state_next = rmth_pkg::CT_INS;
                end
            end
            rmth_pkg::CT_INS:
            begin
                drop_next  = 1'b0;
                if (lo_sts.count == up_sts.count &&
                    lo_sts.count == rmth_pkg::cnt_t'(rmth_pkg::HEAP_DEPTH))
                begin
                    drop_next  = 1'b1;
                    state_next = rmth_pkg::CT_RES_RD;
                end
                else if (lo_sts.count == up_sts.count)
                begin
                    lo_cmd.start = 1'b1;
                    lo_cmd.op    = rmth_pkg::OP_PUSH;
                    lo_cmd.value = smp_reg;
                    state_next   = rmth_pkg::CT_INS_W;
                end
                else
                begin
                    up_cmd.start = 1'b1;
                    up_cmd.op    = rmth_pkg::OP_PUSH;
                    up_cmd.value = smp_reg;
                    state_next   = rmth_pkg::CT_INS_W;
                end
            end
            rmth_pkg::CT_INS_W:
            begin
                if (lo_sts.done || up_sts.done)
                begin
                    state_next = rmth_pkg::CT_TOPS;
                end
            end
            rmth_pkg::CT_TOPS:
            begin
                lo_cmd.top_rd = 1'b1;
                up_cmd.top_rd = 1'b1;
                state_next    = rmth_pkg::CT_TOPS_W;
            end
            rmth_pkg::CT_TOPS_W:
            begin
                state_next = rmth_pkg::CT_TOPS_CHK;
            end
            rmth_pkg::CT_TOPS_CHK:
            begin
                a_next = lo_sts.top;
                b_next = up_sts.top;
                if (lo_sts.count != '0 && up_sts.count != '0 && lo_sts.top > up_sts.top)
                begin
                    state_next = rmth_pkg::CT_POPL;
                end
                else
                begin
                    state_next = rmth_pkg::CT_RES_RD;
                end
            end
            rmth_pkg::CT_POPL:
            begin
                lo_cmd.start = 1'b1;
                lo_cmd.op    = rmth_pkg::OP_POP;
                state_next   = rmth_pkg::CT_POPL_W;
            end
            rmth_pkg::CT_POPL_W:
            begin
                if (lo_sts.done)
                begin
                    state_next = rmth_pkg::CT_POPU;
                end
            end
            rmth_pkg::CT_POPU:
            begin
                up_cmd.start = 1'b1;
                up_cmd.op    = rmth_pkg::OP_POP;
                state_next   = rmth_pkg::CT_POPU_W;
            end
            rmth_pkg::CT_POPU_W:
            begin
                if (up_sts.done)
                begin
                    state_next = rmth_pkg::CT_PUSHL;
                end
            end
            rmth_pkg::CT_PUSHL:
            begin
                lo_cmd.start = 1'b1;
                lo_cmd.op    = rmth_pkg::OP_PUSH;
                lo_cmd.value = b_reg;
                state_next   = rmth_pkg::CT_PUSHL_W;
            end
            rmth_pkg::CT_PUSHL_W:
            begin
                if (lo_sts.done)
                begin
                    state_next = rmth_pkg::CT_PUSHU;
                end
            end
            rmth_pkg::CT_PUSHU:
            begin
                up_cmd.start = 1'b1;
                up_cmd.op    = rmth_pkg::OP_PUSH;
                up_cmd.value = a_reg;
                state_next   = rmth_pkg::CT_PUSHU_W;
            end
            rmth_pkg::CT_PUSHU_W:
            begin
                if (up_sts.done)
                begin
                    state_next = rmth_pkg::CT_RES_RD;
                end
            end
            rmth_pkg::CT_RES_RD:
            begin
                lo_cmd.top_rd = 1'b1;
                state_next    = rmth_pkg::CT_OUT;
            end
            rmth_pkg::CT_OUT:
            begin
                result_valid = 1'b1;
                if (result_ready)
                begin
                    state_next = rmth_pkg::CT_IDLE;
                end
            end
            default:
            begin
                state_next = rmth_pkg::CT_IDLE;
            end
        endcase
    end

    // The top read lands in the cycle after it is issued and holds while idle.
    assign median     = (lo_sts.count == '0) ? '0 : lo_sts.top;
    assign held_count = 14'(lo_sts.count) + 14'(up_sts.count);
    assign dropped    = drop_reg;
endmodule

/* rtl/running_median_two_heaps_unit.sv */
// ----------------------------------------------------------------------------
// running_median_two_heaps_unit
// Running lower median over a max-heap and a min-heap.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries one signed sample and a restart flag.
// Restart empties both heaps before the sample is inserted. Each input
// transfer yields one output transfer with the lower median, the number of
// samples held and a dropped flag for a sample refused by full heaps.
// The block takes one item at a time: sample_ready is high only while idle.
// Work per item: each heap push or pop is a sift of up to log2(4096) = 12
// levels over the heap's single memory port; a push level reads the parent,
// waits and compares, and a pop level reads both children, waits and compares.
// An item takes one insert, a top compare and, when the tops cross, two pops
// and two pushes in turn.
// A new sample is taken in the cycle after the result transfer.
// The result holds on the output ports until result_ready takes it; no new
// sample is accepted meanwhile. Reset empties both heaps at once; heap
// memory needs no clearing because entries above the counts are never used.
// ----------------------------------------------------------------------------
module running_median_two_heaps_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  logic signed [31:0] sample,
    input  logic               restart,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] median,
    output logic [13:0]        held_count,
    output logic               dropped
);
    rmth_pkg::heap_cmd_t lo_cmd, up_cmd;
    rmth_pkg::heap_sts_t lo_sts, up_sts;
    logic                clear;

    rmth_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .restart      (restart),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .median       (median),
        .held_count   (held_count),
        .dropped      (dropped),
        .clear        (clear),
        .lo_cmd       (lo_cmd),
        .up_cmd       (up_cmd),
        .lo_sts       (lo_sts),
        .up_sts       (up_sts)
    );

    rmth_heap u_lower (
        .clk    (clk),
        .rst_n  (rst_n),
        .is_max (1'b1),
        .clear  (clear),
        .cmd    (lo_cmd),
        .sts    (lo_sts)
    );

    rmth_heap u_upper (
        .clk    (clk),
        .rst_n  (rst_n),
        .is_max (1'b0),
        .clear  (clear),
        .cmd    (up_cmd),
        .sts    (up_sts)
    );
endmodule

/* rtl/rmth_checker.sv */
// ----------------------------------------------------------------------------
// rmth_checker
// Port-level checks on the running median block.
// ----------------------------------------------------------------------------
`include "running_median_two_heaps_unit_macros.svh"
module rmth_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic signed [31:0] median,
    input logic [13:0]        held_count,
    input logic               dropped
);
    // One item at a time: never ready to take a sample while a result waits.
    `RM_ASSERT_IMP(a_excl, clk, rst_n, result_valid, !sample_ready, "ready with result pending")
    // An accepted sample makes the block busy.
    `RM_ASSERT_NXT(a_busy, clk, rst_n, sample_valid && sample_ready, !sample_ready, "still ready")
    // A stalled result keeps its fields.
    `RM_ASSERT_NXT(a_hold, clk, rst_n, result_valid && !result_ready,
        result_valid && $stable(median) && $stable(held_count) && $stable(dropped),
        "result changed while stalled")
    // The heaps never report more than their capacity.
    `RM_ASSERT_IMP(a_cap, clk, rst_n, result_valid, held_count <= 14'd8192, "count too big")
endmodule

bind running_median_two_heaps_unit rmth_checker u_rmth_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .median       (median),
    .held_count   (held_count),
    .dropped      (dropped)
);
